// ===== hw/rtl/pswc_pkg.sv =====
`default_nettype none
package pswc_pkg;

  localparam int unsigned TIME_W  = 64;
  localparam int unsigned COUNT_W = 32;
  localparam int unsigned SEC_W   = 35;
  localparam int unsigned EV_W    = 64;
  localparam int unsigned ACT_W   = 32;
  localparam int unsigned SUM_W   = 64;

  localparam int unsigned MUL_W       = 32;
  localparam int unsigned NS_SHIFT    = 9;
  localparam int unsigned RECIP_SHIFT = 29;
  localparam int unsigned REM_W       = 25;
  localparam logic [MUL_W-1:0] NS_ODD =
    MUL_W'(64'd1000000000 >> NS_SHIFT);
  localparam logic [MUL_W-1:0] NS_RECIP =
    MUL_W'((64'd1 << (MUL_W + RECIP_SHIFT)) / 64'd1000000000);
  localparam int unsigned SLOT_SHIFT = 37;
  localparam int unsigned SEST_W     = MUL_W + SEC_W - SLOT_SHIFT;
  localparam int unsigned SREM_W     = 10;

  localparam int unsigned WIN_LONG  = 60;
  localparam int unsigned WIN_MID   = 30;
  localparam int unsigned WIN_SHORT = 10;

  localparam logic FUNC_RECORD = 1'b0;
  localparam logic FUNC_REPORT = 1'b1;

  typedef struct packed {
    logic [SEC_W-1:0] second;
    logic [EV_W-1:0]  evidence;
    logic [ACT_W-1:0] active;
  } bucket_t;

  typedef struct packed {
    logic             done;
    logic [SEC_W-1:0] sec;
  } div_res_t;

  typedef struct packed {
    logic [SUM_W-1:0] e60;
    logic [SUM_W-1:0] e30;
    logic [SUM_W-1:0] e10;
    logic [SUM_W-1:0] a60;
    logic [SUM_W-1:0] a30;
    logic [SUM_W-1:0] a10;
  } win_sums_t;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_DIV   = 7'b0000010,
    S_RREAD = 7'b0000100,
    S_RMW   = 7'b0001000,
    S_SWEEP = 7'b0010000,
    S_DRAIN = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  typedef enum logic [6:0] {
    D_IDLE = 7'b0000001,
    D_EST  = 7'b0000010,
    D_REM  = 7'b0000100,
    D_FIX  = 7'b0001000,
    D_SEST = 7'b0010000,
    D_SREM = 7'b0100000,
    D_SFIX = 7'b1000000
  } div_state_t;

endpackage
`default_nettype wire

// ===== hw/rtl/pswc_if.sv =====
`default_nettype none
interface pswc_in_if;
  import pswc_pkg::*;

  logic               valid;
  logic               ready;
  logic               func;
  logic [TIME_W-1:0]  time_ns;
  logic [COUNT_W-1:0] access_count;

  modport source (output valid, output func, output time_ns, output access_count,
                  input ready);
  modport sink (input valid, input func, input time_ns, input access_count,
                output ready);
endinterface

interface pswc_out_if;
  import pswc_pkg::*;

  logic             valid;
  logic             ready;
  logic [SUM_W-1:0] evidence_60s;
  logic [SUM_W-1:0] evidence_30s;
  logic [SUM_W-1:0] evidence_10s;
  logic [SUM_W-1:0] active_60s;
  logic [SUM_W-1:0] active_30s;
  logic [SUM_W-1:0] active_10s;

  modport source (output valid, output evidence_60s, output evidence_30s,
                  output evidence_10s, output active_60s, output active_30s,
                  output active_10s, input ready);
  modport sink (input valid, input evidence_60s, input evidence_30s,
                input evidence_10s, input active_60s, input active_30s,
                input active_10s, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/pswc_ram.sv =====
`default_nettype none
module pswc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

// ===== hw/rtl/pswc_sec_div.sv =====
`default_nettype none
module pswc_sec_div #(
  parameter int unsigned BUCKETS = 64
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic [pswc_pkg::TIME_W-1:0] time_ns,
  output pswc_pkg::div_res_t               res,
  output logic [$clog2(BUCKETS)-1:0]       slot
);
  import pswc_pkg::*;

  localparam int unsigned SLOT_W = $clog2(BUCKETS);
  localparam logic [MUL_W-1:0] SLOT_RECIP =
    MUL_W'((64'd1 << SLOT_SHIFT) / 64'(BUCKETS));
  localparam logic [SREM_W-1:0] SLOT_MOD = SREM_W'(BUCKETS);

  div_state_t         dstate;
  logic [MUL_W-1:0]   xhi;
  logic [REM_W-1:0]   xlo;
  logic [SEC_W-1:0]   quo;
  logic [REM_W-1:0]   rem;
  logic [SEST_W-1:0]  sest;
  logic [SREM_W-1:0]  srem;
  logic [SLOT_W-1:0]  mrem;
  logic               done;

  logic [MUL_W-1:0]   mul_a;
  logic [MUL_W-1:0]   mul_b;
  logic [2*MUL_W-1:0] mul_p;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (dstate)
      D_EST: begin
        mul_a = xhi;
        mul_b = NS_RECIP;
      end
      D_REM: begin
        mul_a = quo[MUL_W-1:0];
        mul_b = NS_ODD;
      end
      D_SEST: begin
        mul_a = quo[SEC_W-1:SEC_W-MUL_W];
        mul_b = SLOT_RECIP;
      end
      D_SREM: begin
        mul_a = MUL_W'(sest);
        mul_b = MUL_W'(BUCKETS);
      end
      default: begin
        mul_a = '0;
      end
    endcase
    mul_p = 64'(mul_a) * 64'(mul_b);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dstate <= D_IDLE;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (dstate)
        D_IDLE: begin
          if (start) begin
            dstate <= D_EST;
          end
        end
        D_EST: dstate <= D_REM;
        D_REM: dstate <= D_FIX;
        D_FIX: begin
          if (rem < REM_W'(NS_ODD)) begin
            dstate <= D_SEST;
          end
        end
        D_SEST: dstate <= D_SREM;
        D_SREM: dstate <= D_SFIX;
        D_SFIX: begin
          dstate <= D_IDLE;
          done   <= 1'b1;
        end
        default: dstate <= D_IDLE;
      endcase
    end
  end

  // The estimate is low by at most seven, so the remainder fits in REM_W bits.
  always_ff @(posedge clk) begin
    case (dstate)
      D_IDLE: begin
        if (start) begin
          xhi <= time_ns[TIME_W-1:TIME_W-MUL_W];
          xlo <= time_ns[NS_SHIFT+REM_W-1:NS_SHIFT];
        end
      end
      D_EST: quo <= mul_p[2*MUL_W-1:RECIP_SHIFT];
      D_REM: rem <= xlo - mul_p[REM_W-1:0];
      D_FIX: begin
        if (rem >= REM_W'(NS_ODD)) begin
          rem <= rem - REM_W'(NS_ODD);
          quo <= quo + SEC_W'(1);
        end
      end
      D_SEST: sest <= mul_p[2*MUL_W-1:2*MUL_W-SEST_W];
      D_SREM: srem <= quo[SREM_W-1:0] - mul_p[SREM_W-1:0];
      D_SFIX: mrem <= (srem >= SLOT_MOD) ? SLOT_W'(srem - SLOT_MOD) : SLOT_W'(srem);
      default: begin
      end
    endcase
  end

  assign res.done = done;
  assign res.sec  = quo;
  assign slot     = mrem;

endmodule
`default_nettype wire

// ===== hw/rtl/pswc_win_acc.sv =====
`default_nettype none
module pswc_win_acc (
  input  wire logic                       clk,
  input  wire logic                       clear,
  input  wire logic                       en,
  input  wire logic [pswc_pkg::SEC_W-1:0] now,
  input  pswc_pkg::bucket_t               entry,
  output pswc_pkg::win_sums_t             sums
);
  import pswc_pkg::*;

  logic             skip;
  logic [SEC_W-1:0] age;
  logic             in60;
  logic             in30;
  logic             in10;
  logic [SUM_W-1:0] ev;
  logic [SUM_W-1:0] act;

  always_comb begin
    skip = (entry.second == '0) || (entry.second > now);
    age  = now - entry.second;
    in60 = !skip && (age < SEC_W'(WIN_LONG));
    in30 = in60 && (age < SEC_W'(WIN_MID));
    in10 = in60 && (age < SEC_W'(WIN_SHORT));
    ev   = SUM_W'(entry.evidence);
    act  = SUM_W'(entry.active);
  end

  always_ff @(posedge clk) begin
    if (clear) begin
      sums <= '0;
    end else if (en) begin
      if (in60) begin
        sums.e60 <= sums.e60 + ev;
        sums.a60 <= sums.a60 + act;
      end
      if (in30) begin
        sums.e30 <= sums.e30 + ev;
        sums.a30 <= sums.a30 + act;
      end
      if (in10) begin
        sums.e10 <= sums.e10 + ev;
        sums.a10 <= sums.a10 + act;
      end
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/per_second_bucket_window_counter_unit.sv =====
// Per-second bucket window counter for one region.
// Requests arrive on req (valid/ready); func selects record or report.
// A record request takes the second of time_ns and adds access_count to the
// bucket of that second, claiming the bucket first if it holds another second.
// A record gives no response and keeps the block busy until its bucket is written back.
// A report request sums evidence and active counts of buckets aged under
// 60, 30 and 10 seconds and gives one response on rsp after it has swept
// every bucket.
// The second and the bucket index come from reciprocal multiplication on one
// shared 32 x 32 multiplier; the quotient estimate takes up to seven
// corrections, which sets the spread in latency. A report then reads the
// bucket RAM one entry a cycle.
// req.ready is high only while no request is in progress.
// The response sits in an output register; the next request is taken while it
// waits, but a new report holds at its end until the old response is taken.
// Reset empties every bucket at once through per-entry valid bits, clears any
// pending response, and the block is ready in the first cycle after reset.
`default_nettype none
module per_second_bucket_window_counter_unit #(
  parameter int unsigned BUCKETS = 64
) (
  input  wire logic   clk,
  input  wire logic   rst,
  pswc_in_if.sink     req,
  pswc_out_if.source  rsp
);
  import pswc_pkg::*;

  localparam int unsigned SLOT_W = $clog2(BUCKETS);
  localparam int unsigned WORD_W = $bits(bucket_t);

  state_t             state;
  state_t             state_next;
  logic               func;
  logic [COUNT_W-1:0] count;
  logic [SLOT_W-1:0]  idx;
  logic [BUCKETS-1:0] vbit;
  logic               vld_q;
  logic               acc_en;

  logic               start;
  div_res_t           div_res;
  logic [SLOT_W-1:0]  slot;
  logic [SLOT_W-1:0]  rd_addr;
  logic [WORD_W-1:0]  rd_word;
  bucket_t            entry;
  bucket_t            cur;
  bucket_t            upd;
  logic [EV_W:0]      ev_sum;
  logic               wr_en;
  logic               out_free;
  win_sums_t          sums;

  assign start    = req.valid && req.ready;
  assign req.ready = (state == S_IDLE);
  assign out_free = !rsp.valid || rsp.ready;
  assign rd_addr  = (state == S_SWEEP) ? idx : slot;
  assign entry    = vld_q ? bucket_t'(rd_word) : '0;
  assign wr_en    = (state == S_RMW);

  pswc_sec_div #(.BUCKETS(BUCKETS)) u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .time_ns (req.time_ns),
    .res     (div_res),
    .slot    (slot)
  );

  pswc_ram #(.WIDTH(WORD_W), .DEPTH(BUCKETS)) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (slot),
    .wr_data (upd),
    .rd_addr (rd_addr),
    .rd_data (rd_word)
  );

  pswc_win_acc u_acc (
    .clk   (clk),
    .clear (start),
    .en    (acc_en),
    .now   (div_res.sec),
    .entry (entry),
    .sums  (sums)
  );

  always_comb begin
    cur = entry;
    if (entry.second != div_res.sec) begin
      cur = '0;
    end
    ev_sum = {1'b0, cur.evidence} + (EV_W + 1)'(count);
    upd.second   = div_res.sec;
    upd.evidence = ev_sum[EV_W] ? '1 : ev_sum[EV_W-1:0];
    upd.active   = cur.active;
    if ((count != '0) && (cur.active != '1)) begin
      upd.active = cur.active + 1'b1;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        if (div_res.done) begin
          state_next = (func == FUNC_REPORT) ? S_SWEEP : S_RREAD;
        end
      end
      S_RREAD: state_next = S_RMW;
      S_RMW:   state_next = S_IDLE;
      S_SWEEP: begin
        if (idx == SLOT_W'(BUCKETS - 1)) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: state_next = S_DONE;
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      vbit      <= '0;
      acc_en    <= 1'b0;
      rsp.valid <= 1'b0;
    end else begin
      state  <= state_next;
      acc_en <= (state == S_SWEEP);
      if (wr_en) begin
        vbit[slot] <= 1'b1;
      end
      if ((state == S_DONE) && out_free) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    vld_q <= vbit[rd_addr];
    if (start) begin
      func  <= req.func;
      count <= req.access_count;
    end
    if (state == S_SWEEP) begin
      idx <= idx + 1'b1;
    end else begin
      idx <= '0;
    end
    if ((state == S_DONE) && out_free) begin
      rsp.evidence_60s <= sums.e60;
      rsp.evidence_30s <= sums.e30;
      rsp.evidence_10s <= sums.e10;
      rsp.active_60s   <= sums.a60;
      rsp.active_30s   <= sums.a30;
      rsp.active_10s   <= sums.a10;
    end
  end

endmodule
`default_nettype wire
